// File: design/spx_pkg.sv
// ----------------------------------------------------------------------------
// spx_pkg
// Shared types, constants and ARX/linear-layer functions for the SPARX-64/128
// style block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package spx_pkg;

	localparam int unsigned WORD_W   = 16;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 64;
	localparam int unsigned ROT_L    = 9;
	localparam int unsigned ROT_R    = 2;
	localparam int unsigned ROT_LIN  = 8;
	localparam int unsigned ROT_RINV = 14;
	localparam int unsigned ROT_LINV = 7;
	localparam logic [3:0]  MAX_STEPS = 4'd8;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [3:0][WORD_W-1:0] block_t;
	typedef logic [7:0][WORD_W-1:0] key_t;

	typedef struct packed {
		word_t l;
		word_t r;
	} pair_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_STEPS    = 2'd2,
		REG_ROUNDS   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEYFWD,
		ST_WHITEN,
		ST_ROUND,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		KOP_HOLD,
		KOP_LOAD,
		KOP_ADV,
		KOP_RET
	} key_op_t;

	typedef enum logic [2:0] {
		DOP_HOLD,
		DOP_LOAD,
		DOP_WHITEN,
		DOP_ENC,
		DOP_DEC
	} dp_op_t;

	typedef struct packed {
		key_op_t    op;
		logic [4:0] base;
	} key_ctrl_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] ri;
		logic       last_round;
	} dp_ctrl_t;

	typedef struct packed {
		key_t       key;
		logic [3:0] steps;
		logic [1:0] rounds;
	} cfg_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic pair_t arx_fwd(input pair_t p);
		pair_t o;
		o.l = rotl(p.l, ROT_L) + p.r;
		o.r = rotl(p.r, ROT_R) ^ o.l;
		return o;
	endfunction

	function automatic pair_t arx_inv(input pair_t p);
		pair_t o;
		o.r = rotl(p.r ^ p.l, ROT_RINV);
		o.l = rotl(p.l - o.r, ROT_LINV);
		return o;
	endfunction

	function automatic key_t kperm(input key_t k, input word_t rc);
		key_t  w;
		key_t  o;
		pair_t t;
		pair_t a;
		a.l = k[0];
		a.r = k[1];
		t = arx_fwd(a);
		w = k;
		w[0] = t.l;
		w[1] = t.r;
		w[2] = k[2] + t.l;
		w[3] = k[3] + t.r;
		w[7] = k[7] + rc;
		o[0] = w[6];
		o[1] = w[7];
		o[2] = w[0];
		o[3] = w[1];
		o[4] = w[2];
		o[5] = w[3];
		o[6] = w[4];
		o[7] = w[5];
		return o;
	endfunction

	function automatic key_t kperm_inv(input key_t k, input word_t rc);
		key_t  o;
		pair_t a;
		pair_t t;
		a.l = k[2];
		a.r = k[3];
		t = arx_inv(a);
		o[0] = t.l;
		o[1] = t.r;
		o[2] = k[4] - k[2];
		o[3] = k[5] - k[3];
		o[4] = k[6];
		o[5] = k[7];
		o[6] = k[0];
		o[7] = k[1] - rc;
		return o;
	endfunction

	function automatic block_t lin(input block_t s);
		block_t o;
		word_t  t;
		t = rotl(s[0] ^ s[1], ROT_LIN);
		o[0] = s[2] ^ s[0] ^ t;
		o[1] = s[3] ^ s[1] ^ t;
		o[2] = s[0];
		o[3] = s[1];
		return o;
	endfunction

	function automatic block_t lin_inv(input block_t s);
		block_t o;
		word_t  t;
		o[0] = s[2];
		o[1] = s[3];
		t = rotl(s[2] ^ s[3], ROT_LIN);
		o[2] = s[0] ^ s[2] ^ t;
		o[3] = s[1] ^ s[3] ^ t;
		return o;
	endfunction

endpackage

`default_nettype wire

// File: design/spx_ifs.sv
// ----------------------------------------------------------------------------
// spx_ifs
// Valid/ready channel interfaces for cipher requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spx_in_if;
	logic                valid;
	logic                ready;
	logic                kind;
	spx_pkg::block_t     block_in;

	modport source (output valid, output kind, output block_in, input ready);
	modport sink   (input valid, input kind, input block_in, output ready);
endinterface

interface spx_out_if;
	logic                valid;
	logic                ready;
	spx_pkg::block_t     block_out;

	modport source (output valid, output block_out, input ready);
	modport sink   (input valid, input block_out, output ready);
endinterface

`default_nettype wire

// File: design/spx_apb_regs.sv
// ----------------------------------------------------------------------------
// spx_apb_regs
// APB-style configuration registers: key halves, step count, rounds per step.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_apb_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [spx_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [spx_pkg::DATA_W-1:0]    pwdata,
	output      logic [spx_pkg::DATA_W-1:0]    prdata,
	output      logic                          pready,
	output      spx_pkg::cfg_t                 cfg
);

	logic [63:0]         key_low_q;
	logic [63:0]         key_high_q;
	logic [3:0]          steps_q;
	logic [1:0]          rounds_q;
	spx_pkg::reg_idx_t   idx;
	logic                wr_en;

	assign idx    = spx_pkg::reg_idx_t'(paddr[4:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			steps_q    <= spx_pkg::MAX_STEPS;
			rounds_q   <= 2'd3;
		end else if (wr_en) begin
			unique case (idx)
				spx_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				spx_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				spx_pkg::REG_STEPS:    steps_q    <= pwdata[3:0];
				spx_pkg::REG_ROUNDS:   rounds_q   <= pwdata[1:0];
				default:               ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			spx_pkg::REG_KEY_LOW:  prdata = key_low_q;
			spx_pkg::REG_KEY_HIGH: prdata = key_high_q;
			spx_pkg::REG_STEPS:    prdata = {60'd0, steps_q};
			spx_pkg::REG_ROUNDS:   prdata = {62'd0, rounds_q};
			default:               prdata = '0;
		endcase
	end

	assign cfg.key    = {key_high_q, key_low_q};
	assign cfg.steps  = steps_q;
	assign cfg.rounds = rounds_q;

endmodule

`default_nettype wire

// File: design/spx_key_sched.sv
// ----------------------------------------------------------------------------
// spx_key_sched
// Round-key pair registers. Holds keys 2c and 2c+1; loads the master key and
// steps two schedule positions forward or back per advance or return command.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_key_sched (
	input  wire logic               clk,
	input  wire spx_pkg::key_ctrl_t ctrl,
	input  wire spx_pkg::key_t      key_in,
	output      spx_pkg::key_t      ka,
	output      spx_pkg::key_t      kb
);

	spx_pkg::key_t ka_q;
	spx_pkg::key_t kb_q;
	spx_pkg::key_t adv_a;
	spx_pkg::key_t adv_b;
	spx_pkg::key_t ret_a;
	spx_pkg::key_t ret_b;
	spx_pkg::key_t load_b;
	spx_pkg::word_t base_w;

	assign base_w = spx_pkg::word_t'(ctrl.base);

	always_comb begin
		load_b = spx_pkg::kperm(key_in, 16'd1);
		adv_a  = spx_pkg::kperm(kb_q, base_w + 16'd2);
		adv_b  = spx_pkg::kperm(adv_a, base_w + 16'd3);
		ret_b  = spx_pkg::kperm_inv(ka_q, base_w);
		ret_a  = spx_pkg::kperm_inv(ret_b, base_w - 16'd1);
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			spx_pkg::KOP_LOAD: begin
				ka_q <= key_in;
				kb_q <= load_b;
			end
			spx_pkg::KOP_ADV: begin
				ka_q <= adv_a;
				kb_q <= adv_b;
			end
			spx_pkg::KOP_RET: begin
				ka_q <= ret_a;
				kb_q <= ret_b;
			end
			default: ;
		endcase
	end

	assign ka = ka_q;
	assign kb = kb_q;

endmodule

`default_nettype wire

// File: design/spx_round_unit.sv
// ----------------------------------------------------------------------------
// spx_round_unit
// Shared round unit: state register, key mixing, ARX rounds on both branches
// and the linear layer, forward or inverse.
// ----------------------------------------------------------------------------
`default_nettype none

module spx_round_unit (
	input  wire logic               clk,
	input  wire spx_pkg::dp_ctrl_t  ctrl,
	input  wire spx_pkg::block_t    blk_in,
	input  wire spx_pkg::key_t      ka,
	input  wire spx_pkg::key_t      kb,
	output      spx_pkg::block_t    blk_out
);

	spx_pkg::block_t s_q;
	spx_pkg::block_t nxt;
	spx_pkg::block_t pre;
	spx_pkg::block_t mix;
	spx_pkg::pair_t  p0;
	spx_pkg::pair_t  p1;
	spx_pkg::pair_t  q0;
	spx_pkg::pair_t  q1;
	logic [2:0]      kl;
	logic [2:0]      kr;

	assign kl = {ctrl.ri, 1'b0};
	assign kr = {ctrl.ri, 1'b1};

	always_comb begin
		pre = ctrl.last_round ? spx_pkg::lin_inv(s_q) : s_q;
		p0  = '0;
		p1  = '0;
		q0  = '0;
		q1  = '0;
		mix = s_q;
		nxt = s_q;
		case (ctrl.op)
			spx_pkg::DOP_LOAD:   nxt = blk_in;
			spx_pkg::DOP_WHITEN: nxt = s_q ^ spx_pkg::block_t'(ka[3:0]);
			spx_pkg::DOP_ENC: begin
				p0.l = s_q[0] ^ ka[kl];
				p0.r = s_q[1] ^ ka[kr];
				p1.l = s_q[2] ^ kb[kl];
				p1.r = s_q[3] ^ kb[kr];
				q0 = spx_pkg::arx_fwd(p0);
				q1 = spx_pkg::arx_fwd(p1);
				mix[0] = q0.l;
				mix[1] = q0.r;
				mix[2] = q1.l;
				mix[3] = q1.r;
				nxt = ctrl.last_round ? spx_pkg::lin(mix) : mix;
			end
			spx_pkg::DOP_DEC: begin
				p0.l = pre[0];
				p0.r = pre[1];
				p1.l = pre[2];
				p1.r = pre[3];
				q0 = spx_pkg::arx_inv(p0);
				q1 = spx_pkg::arx_inv(p1);
				nxt[0] = q0.l ^ ka[kl];
				nxt[1] = q0.r ^ ka[kr];
				nxt[2] = q1.l ^ kb[kl];
				nxt[3] = q1.r ^ kb[kr];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		s_q <= nxt;
	end

	assign blk_out = s_q;

endmodule

`default_nettype wire

// File: design/sparx64_block_cipher_top.sv
// ----------------------------------------------------------------------------
// sparx64_block_cipher_top
// SPARX-64/128 style encrypt/decrypt engine with configurable steps and
// rounds per step, one shared round unit under a small sequencer.
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        kind, block_in
//   out_ch    out   valid/ready        block_out
//   apb       in    psel/penable       paddr, pwdata, prdata (64-bit regs)
//
// Encrypt: rounds on the accepted block, then final whitening, then the result.
// Decrypt: key schedule walked forward first, then whitening and inverse rounds.
// The round unit does one round on both branches per cycle.
// Input ready only while idle; a finished result waits in the output register,
// so the next transaction may start while the previous one is still unread.
// Reset clears configuration to its defaults and the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sparx64_block_cipher_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	spx_in_if.sink                             in_ch,
	spx_out_if.source                          out_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [spx_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [spx_pkg::DATA_W-1:0]    pwdata,
	output      logic [spx_pkg::DATA_W-1:0]    prdata,
	output      logic                          pready
);

	spx_pkg::cfg_t      cfg;
	spx_pkg::state_t    state_q;
	spx_pkg::state_t    state_nxt;
	spx_pkg::key_ctrl_t key_ctrl;
	spx_pkg::dp_ctrl_t  dp_ctrl;
	spx_pkg::key_t      ka;
	spx_pkg::key_t      kb;
	spx_pkg::block_t    dp_out;
	spx_pkg::block_t    block_out_q;

	logic       kind_q;
	logic [3:0] steps_q;
	logic [1:0] rounds_q;
	logic [3:0] step_q;
	logic [1:0] ri_q;
	logic       out_valid_q;
	logic [3:0] steps_eff;
	logic [1:0] rounds_eff;
	logic       in_acc;
	logic       last_ri;
	logic       step_end;
	logic       out_free;
	logic       load_out;

	spx_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	spx_key_sched u_keys (
		.clk    (clk),
		.ctrl   (key_ctrl),
		.key_in (cfg.key),
		.ka     (ka),
		.kb     (kb)
	);

	spx_round_unit u_round (
		.clk     (clk),
		.ctrl    (dp_ctrl),
		.blk_in  (in_ch.block_in),
		.ka      (ka),
		.kb      (kb),
		.blk_out (dp_out)
	);

	always_comb begin
		if (cfg.steps == 4'd0) begin
			steps_eff = 4'd1;
		end else if (cfg.steps > spx_pkg::MAX_STEPS) begin
			steps_eff = spx_pkg::MAX_STEPS;
		end else begin
			steps_eff = cfg.steps;
		end
		rounds_eff = (cfg.rounds == 2'd0) ? 2'd1 : cfg.rounds;
	end

	assign in_acc    = (state_q == spx_pkg::ST_IDLE) & in_ch.valid;
	assign last_ri   = (ri_q == rounds_q - 2'd1);
	assign step_end  = (step_q == steps_q - 4'd1);
	assign out_free  = ~out_valid_q | out_ch.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spx_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_nxt = in_ch.kind ? spx_pkg::ST_KEYFWD : spx_pkg::ST_ROUND;
				end
			end
			spx_pkg::ST_KEYFWD: begin
				if (step_end) begin
					state_nxt = spx_pkg::ST_WHITEN;
				end
			end
			spx_pkg::ST_WHITEN: begin
				state_nxt = kind_q ? spx_pkg::ST_ROUND : spx_pkg::ST_DONE;
			end
			spx_pkg::ST_ROUND: begin
				if (!kind_q && last_ri && step_end) begin
					state_nxt = spx_pkg::ST_WHITEN;
				end else if (kind_q && ri_q == 2'd0 && step_q == 4'd0) begin
					state_nxt = spx_pkg::ST_DONE;
				end
			end
			spx_pkg::ST_DONE: begin
				if (out_free) begin
					state_nxt = spx_pkg::ST_IDLE;
				end
			end
			default: state_nxt = spx_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready        = 1'b0;
		load_out           = 1'b0;
		key_ctrl.op        = spx_pkg::KOP_HOLD;
		key_ctrl.base      = {step_q, 1'b0};
		dp_ctrl.op         = spx_pkg::DOP_HOLD;
		dp_ctrl.ri         = ri_q;
		dp_ctrl.last_round = last_ri;
		unique case (state_q)
			spx_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					key_ctrl.op = spx_pkg::KOP_LOAD;
					dp_ctrl.op  = spx_pkg::DOP_LOAD;
				end
			end
			spx_pkg::ST_KEYFWD: begin
				key_ctrl.op = spx_pkg::KOP_ADV;
			end
			spx_pkg::ST_WHITEN: begin
				dp_ctrl.op = spx_pkg::DOP_WHITEN;
				if (kind_q) begin
					key_ctrl.op = spx_pkg::KOP_RET;
				end
			end
			spx_pkg::ST_ROUND: begin
				if (kind_q) begin
					dp_ctrl.op = spx_pkg::DOP_DEC;
					if (ri_q == 2'd0) begin
						key_ctrl.op = spx_pkg::KOP_RET;
					end
				end else begin
					dp_ctrl.op = spx_pkg::DOP_ENC;
					if (last_ri) begin
						key_ctrl.op = spx_pkg::KOP_ADV;
					end
				end
			end
			spx_pkg::ST_DONE: begin
				load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spx_pkg::ST_IDLE;
			kind_q   <= 1'b0;
			steps_q  <= 4'd1;
			rounds_q <= 2'd1;
			step_q   <= 4'd0;
			ri_q     <= 2'd0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				spx_pkg::ST_IDLE: begin
					if (in_acc) begin
						kind_q   <= in_ch.kind;
						steps_q  <= steps_eff;
						rounds_q <= rounds_eff;
						step_q   <= 4'd0;
						ri_q     <= in_ch.kind ? rounds_eff - 2'd1 : 2'd0;
					end
				end
				spx_pkg::ST_KEYFWD: step_q <= step_q + 4'd1;
				spx_pkg::ST_WHITEN: begin
					if (kind_q) begin
						step_q <= step_q - 4'd1;
						ri_q   <= rounds_q - 2'd1;
					end
				end
				spx_pkg::ST_ROUND: begin
					if (kind_q) begin
						if (ri_q == 2'd0) begin
							ri_q <= rounds_q - 2'd1;
							if (step_q != 4'd0) begin
								step_q <= step_q - 4'd1;
							end
						end else begin
							ri_q <= ri_q - 2'd1;
						end
					end else if (last_ri) begin
						ri_q   <= 2'd0;
						step_q <= step_q + 4'd1;
					end else begin
						ri_q <= ri_q + 2'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			block_out_q <= dp_out;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.block_out = block_out_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != spx_pkg::ST_IDLE)
		else $error("sequencer stayed idle after accepting a transaction");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != spx_pkg::ST_IDLE |-> step_q <= steps_q)
		else $error("step counter beyond configured step count");

	a_round_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spx_pkg::ST_ROUND |-> ri_q < rounds_q)
		else $error("round index beyond rounds per step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q && $stable(block_out_q))
		else $error("pending result overwritten or dropped");

endmodule

`default_nettype wire
